[src/subtour_and_capacity_set_finder_core_defines.svh]
// Assertion macros used by the set finder controller
`ifndef SUBTOUR_AND_CAPACITY_SET_FINDER_CORE_DEFINES_SVH
`define SUBTOUR_AND_CAPACITY_SET_FINDER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SCSF_AST_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SCSF_AST_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/scsf_pkg.sv]
// Types, constants and codes of the subtour and capacity set finder
package scsf_pkg;

  localparam int MAX_NODES  = 32;
  localparam int NODE_W     = 5;
  localparam int CNT_W      = 6;
  localparam int VALUE_W    = 16;
  localparam int DEM_W      = 16;
  localparam int CAP_W      = 16;
  localparam int SUM_W      = 21;
  localparam int ARC_AW     = 2 * NODE_W;
  localparam int ARC_DEPTH  = MAX_NODES * MAX_NODES;
  localparam int MAX_RESULTS = 63;
  localparam logic [CNT_W-1:0] MAX_SET_ITEMS = CNT_W'(MAX_RESULTS - 1);
  localparam logic [CNT_W-1:0] NODES_LIMIT   = CNT_W'(MAX_NODES);

  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_CAPACITY   = 1'b1;

  localparam logic KIND_SUBTOUR = 1'b0;
  localparam logic KIND_ROUTE   = 1'b1;

  typedef enum logic [1:0] {
    OP_ARC  = 2'd0,
    OP_DEM  = 2'd1,
    OP_FIND = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_B_POP, ST_B_CUR, ST_A_RD, ST_A_EV, ST_S_SEED, ST_E_RD, ST_E_WR,
    ST_R_J, ST_R_JEV, ST_R_VISIT, ST_R_RD, ST_R_EV, ST_R_END, ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_REACH, PH_SUB, PH_ROUTE
  } phase_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [NODE_W-1:0]  from_node;
    logic [NODE_W-1:0]  to_node;
    logic [VALUE_W-1:0] arc_value;
    logic [DEM_W-1:0]   demand;
    logic [VALUE_W-1:0] threshold;
  } in_word_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_id;
    logic              set_kind;
    logic              last_of_set;
    logic              done_res;
  } out_word_t;

  typedef struct packed {
    logic load_arc;
    logic load_dem;
    logic find_start;
    logic pop;
    logic load_cur;
    logic arc_rd_scan;
    logic arc_rd_j;
    logic bfs_add;
    logic k_inc;
    logic proc_init;
    logic seed_start;
    logic s_inc;
    logic emit_init;
    logic emit_kind;
    logic emit_rd;
    logic emit_wr;
    logic route_init;
    logic route_start;
    logic visit;
    logic set_cur;
    logic done_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic head_eq_tail;
    logic k_eq_n;
    logic s_ge_n;
    logic s_skip;
    logic scan_add;
    logic route_hit;
    logic j_take;
    logic cur_stop;
    logic i_eq_len;
    logic over_cap;
    logic out_free;
  } dp_sts_t;

endpackage

[src/scsf_ram.sv]
// Generic single-write, single-read RAM with registered read data
module scsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/scsf_dp.sv]
// Datapath: arc, demand and queue memories, masks, counters and result register
module scsf_dp
  import scsf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_word_t              in_data,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [CAP_W-1:0]      cfg_wdata,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data
);

  logic [CNT_W-1:0]     node_count_r;
  logic [CAP_W-1:0]     cap_r;
  logic [CNT_W-1:0]     n_r;
  logic [VALUE_W-1:0]   thr_r;
  logic [MAX_NODES-1:0] reach_r, proc_r, rvis_r;
  logic [CNT_W-1:0]     head_r, tail_r, k_r, s_r, i_r, cnt_r;
  logic [NODE_W-1:0]    cur_r;
  logic [SUM_W-1:0]     sum_r;
  logic                 mode_r, kind_r;
  logic                 out_valid_r;
  out_word_t            out_r;

  logic                 arc_we, arc_re;
  logic [ARC_AW-1:0]    arc_waddr, arc_raddr;
  logic [VALUE_W-1:0]   arc_rdata;
  logic                 q_we, q_re;
  logic [NODE_W-1:0]    q_waddr, q_wdata, q_raddr, q_rdata;
  logic                 dem_re;
  logic [NODE_W-1:0]    dem_raddr;
  logic [DEM_W-1:0]     dem_rdata;
  logic                 arc_gt, mask_k, out_free, out_load;

  assign arc_we    = cmd.load_arc;
  assign arc_waddr = {in_data.from_node, in_data.to_node};
  assign arc_re    = cmd.arc_rd_scan | cmd.arc_rd_j;
  assign arc_raddr = cmd.arc_rd_j ? {NODE_W'(0), s_r[NODE_W-1:0]}
                                  : {cur_r, k_r[NODE_W-1:0]};

  scsf_ram #(.WIDTH(VALUE_W), .DEPTH(ARC_DEPTH)) u_arc_ram (
    .clk(clk), .we(arc_we), .waddr(arc_waddr), .wdata(in_data.arc_value),
    .re(arc_re), .raddr(arc_raddr), .rdata(arc_rdata)
  );

  // fetch the demand of the node that becomes current, ready for the visit
  assign dem_re    = cmd.route_start | cmd.set_cur;
  assign dem_raddr = cmd.route_start ? s_r[NODE_W-1:0] : k_r[NODE_W-1:0];

  scsf_ram #(.WIDTH(DEM_W), .DEPTH(MAX_NODES)) u_dem_ram (
    .clk(clk), .we(cmd.load_dem), .waddr(in_data.from_node), .wdata(in_data.demand),
    .re(dem_re), .raddr(dem_raddr), .rdata(dem_rdata)
  );

  always_comb begin
    q_we    = 1'b0;
    q_waddr = tail_r[NODE_W-1:0];
    q_wdata = cur_r;
    if (cmd.find_start) begin
      q_we    = 1'b1;
      q_waddr = '0;
      q_wdata = '0;
    end else if (cmd.seed_start) begin
      q_we    = 1'b1;
      q_waddr = '0;
      q_wdata = s_r[NODE_W-1:0];
    end else if (cmd.bfs_add) begin
      q_we    = 1'b1;
      q_wdata = k_r[NODE_W-1:0];
    end else if (cmd.visit) begin
      q_we    = 1'b1;
    end
  end

  assign q_re    = cmd.pop | cmd.emit_rd;
  assign q_raddr = cmd.pop ? head_r[NODE_W-1:0] : i_r[NODE_W-1:0];

  scsf_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
  );

  assign arc_gt   = arc_rdata > thr_r;
  assign mask_k   = mode_r ? proc_r[k_r[NODE_W-1:0]] : reach_r[k_r[NODE_W-1:0]];
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (cmd.emit_wr && (cnt_r < MAX_SET_ITEMS)) || cmd.done_wr;

  always_comb begin
    sts.head_eq_tail = head_r == tail_r;
    sts.k_eq_n       = k_r == n_r;
    sts.s_ge_n       = s_r >= n_r;
    sts.s_skip       = reach_r[s_r[NODE_W-1:0]] | proc_r[s_r[NODE_W-1:0]];
    sts.route_hit    = arc_gt && (cur_r != k_r[NODE_W-1:0]);
    sts.scan_add     = sts.route_hit && !mask_k;
    sts.j_take       = arc_gt && !rvis_r[s_r[NODE_W-1:0]];
    sts.cur_stop     = (cur_r == '0) || rvis_r[cur_r];
    sts.i_eq_len     = i_r == tail_r;
    sts.over_cap     = (sum_r > SUM_W'(cap_r)) && (tail_r != '0);
    sts.out_free     = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODES_LIMIT;
      cap_r        <= '0;
      out_valid_r  <= 1'b0;
      reach_r      <= '0;
      proc_r       <= '0;
      rvis_r       <= '0;
      sum_r        <= '0;
      cnt_r        <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      k_r          <= '0;
      s_r          <= '0;
      i_r          <= '0;
      cur_r        <= '0;
      mode_r       <= 1'b0;
      kind_r       <= KIND_SUBTOUR;
      n_r          <= '0;
      thr_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_NODE_COUNT) begin
          node_count_r <= cfg_wdata[CNT_W-1:0];
        end else begin
          cap_r <= cfg_wdata;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.find_start) begin
        n_r     <= (node_count_r > NODES_LIMIT) ? NODES_LIMIT : node_count_r;
        thr_r   <= in_data.threshold;
        reach_r <= MAX_NODES'(1);
        tail_r  <= CNT_W'(1);
        head_r  <= '0;
        mode_r  <= 1'b0;
        cnt_r   <= '0;
      end
      if (cmd.pop) begin
        head_r <= head_r + CNT_W'(1);
      end
      if (cmd.load_cur) begin
        cur_r <= q_rdata;
        k_r   <= '0;
      end
      if (cmd.bfs_add) begin
        if (mode_r) begin
          proc_r[k_r[NODE_W-1:0]] <= 1'b1;
        end else begin
          reach_r[k_r[NODE_W-1:0]] <= 1'b1;
        end
        tail_r <= tail_r + CNT_W'(1);
      end
      if (cmd.k_inc) begin
        k_r <= k_r + CNT_W'(1);
      end
      if (cmd.proc_init) begin
        proc_r <= MAX_NODES'(1);
        s_r    <= CNT_W'(1);
      end
      if (cmd.seed_start) begin
        proc_r[s_r[NODE_W-1:0]] <= 1'b1;
        tail_r <= CNT_W'(1);
        head_r <= '0;
        mode_r <= 1'b1;
      end
      if (cmd.s_inc) begin
        s_r <= s_r + CNT_W'(1);
      end
      if (cmd.emit_init) begin
        i_r    <= '0;
        kind_r <= cmd.emit_kind;
      end
      if (cmd.emit_wr) begin
        // drop set words past the result limit
        if (cnt_r < MAX_SET_ITEMS) begin
          out_r.node_id     <= q_rdata;
          out_r.set_kind    <= kind_r;
          out_r.last_of_set <= (i_r + CNT_W'(1)) == tail_r;
          out_r.done_res    <= 1'b0;
          cnt_r             <= cnt_r + CNT_W'(1);
        end
        i_r <= i_r + CNT_W'(1);
      end
      if (cmd.route_init) begin
        rvis_r <= MAX_NODES'(1);
        s_r    <= CNT_W'(1);
      end
      if (cmd.route_start) begin
        cur_r  <= s_r[NODE_W-1:0];
        tail_r <= '0;
        sum_r  <= '0;
      end
      if (cmd.visit) begin
        rvis_r[cur_r] <= 1'b1;
        tail_r        <= tail_r + CNT_W'(1);
        sum_r         <= sum_r + SUM_W'(dem_rdata);
        k_r           <= '0;
      end
      if (cmd.set_cur) begin
        cur_r <= k_r[NODE_W-1:0];
      end
      if (cmd.done_wr) begin
        out_r.node_id     <= '0;
        out_r.set_kind    <= KIND_SUBTOUR;
        out_r.last_of_set <= 1'b0;
        out_r.done_res    <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/scsf_ctrl.sv]
// Controller: sequences loads, the graph searches, route walks and set output
`include "subtour_and_capacity_set_finder_core_defines.svh"
module scsf_ctrl
  import scsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  dp_sts_t     sts,
  output dp_cmd_t     cmd
);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_REACH;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign in_stall = state_r != ST_IDLE;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_ARC:  cmd.load_arc = 1'b1;
            OP_DEM:  cmd.load_dem = 1'b1;
            OP_FIND: begin
              cmd.find_start = 1'b1;
              phase_nxt      = PH_REACH;
              state_nxt      = ST_B_POP;
            end
            default: ;
          endcase
        end
      end
      ST_B_POP: begin
        if (sts.head_eq_tail) begin
          if (phase_r == PH_REACH) begin
            cmd.proc_init = 1'b1;
            phase_nxt     = PH_SUB;
            state_nxt     = ST_S_SEED;
          end else begin
            cmd.emit_init = 1'b1;
            cmd.emit_kind = KIND_SUBTOUR;
            state_nxt     = ST_E_RD;
          end
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = ST_B_CUR;
        end
      end
      ST_B_CUR: begin
        cmd.load_cur = 1'b1;
        state_nxt    = ST_A_RD;
      end
      ST_A_RD: begin
        if (sts.k_eq_n) begin
          state_nxt = ST_B_POP;
        end else begin
          cmd.arc_rd_scan = 1'b1;
          state_nxt       = ST_A_EV;
        end
      end
      ST_A_EV: begin
        cmd.bfs_add = sts.scan_add;
        cmd.k_inc   = 1'b1;
        state_nxt   = ST_A_RD;
      end
      ST_S_SEED: begin
        if (sts.s_ge_n) begin
          cmd.route_init = 1'b1;
          phase_nxt      = PH_ROUTE;
          state_nxt      = ST_R_J;
        end else if (sts.s_skip) begin
          cmd.s_inc = 1'b1;
        end else begin
          cmd.seed_start = 1'b1;
          state_nxt      = ST_B_POP;
        end
      end
      ST_E_RD: begin
        if (sts.i_eq_len) begin
          cmd.s_inc = 1'b1;
          state_nxt = (phase_r == PH_ROUTE) ? ST_R_J : ST_S_SEED;
        end else begin
          cmd.emit_rd = 1'b1;
          state_nxt   = ST_E_WR;
        end
      end
      ST_E_WR: begin
        if (sts.out_free) begin
          cmd.emit_wr = 1'b1;
          state_nxt   = ST_E_RD;
        end
      end
      ST_R_J: begin
        if (sts.s_ge_n) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.arc_rd_j = 1'b1;
          state_nxt    = ST_R_JEV;
        end
      end
      ST_R_JEV: begin
        if (sts.j_take) begin
          cmd.route_start = 1'b1;
          state_nxt       = ST_R_VISIT;
        end else begin
          cmd.s_inc = 1'b1;
          state_nxt = ST_R_J;
        end
      end
      ST_R_VISIT: begin
        if (sts.cur_stop) begin
          state_nxt = ST_R_END;
        end else begin
          cmd.visit = 1'b1;
          state_nxt = ST_R_RD;
        end
      end
      ST_R_RD: begin
        if (sts.k_eq_n) begin
          state_nxt = ST_R_END;
        end else begin
          cmd.arc_rd_scan = 1'b1;
          state_nxt       = ST_R_EV;
        end
      end
      ST_R_EV: begin
        if (sts.route_hit) begin
          cmd.set_cur = 1'b1;
          state_nxt   = ST_R_VISIT;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = ST_R_RD;
        end
      end
      ST_R_END: begin
        if (sts.over_cap) begin
          cmd.emit_init = 1'b1;
          cmd.emit_kind = KIND_ROUTE;
          state_nxt     = ST_E_RD;
        end else begin
          cmd.s_inc = 1'b1;
          state_nxt = ST_R_J;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.done_wr = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `SCSF_AST_NEXT(a_find_leaves_idle, cmd.find_start, state_r == ST_B_POP, "find did not start search")
  `SCSF_AST_NOW(a_emit_slot_free, cmd.emit_wr || cmd.done_wr, sts.out_free, "word written over pending result")
  `SCSF_AST_NEXT(a_done_returns_idle, cmd.done_wr, state_r == ST_IDLE && !in_stall, "run did not close")

endmodule

[src/subtour_and_capacity_set_finder_core.sv]
// Top level of the subtour and capacity set finder
//
//  channel | direction | handshake            | word
//  in_     | input     | in_valid / in_stall  | in_word_t (op, nodes, value, demand, thr)
//  out_    | output    | out_valid / out_stall| out_word_t (node_id, kind, last, done)
//  cfg_    | input     | cfg_wr_en            | cfg_index, cfg_wdata
//
// Arc and demand loads are accepted back to back. Every arc lookup of a find
// goes through the single registered read port of the arc RAM.
// Reset is synchronous; arc, demand and queue memories are not cleared.
// in_stall stays high for the whole find; out_stall holds the result word and
// the engine waits on it.
module subtour_and_capacity_set_finder_core
  import scsf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_data,
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic [CAP_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  scsf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_data.op), .sts(sts), .cmd(cmd)
  );

  scsf_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

[tb/sv/tb_subtour_and_capacity_set_finder_core.sv]
// Testbench of the subtour and capacity set finder: directed table, then random words
module tb_subtour_and_capacity_set_finder_core;
  import scsf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // nodes whose arcs and demands are preloaded; node counts stay within it
  localparam int FILL_NODES = 12;
  localparam int IN_W       = $bits(in_word_t);

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_word_t         in_data;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_data;
  logic             cfg_wr_en;
  logic             cfg_index;
  logic [CAP_W-1:0] cfg_wdata;

  subtour_and_capacity_set_finder_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  typedef struct {
    bit               is_cfg;
    logic             cidx;
    logic [CAP_W-1:0] cval;
    in_word_t         w;
    bit               typed;
    out_word_t        ex;
  } dir_row_t;

  // mirror of the block's state
  logic [VALUE_W-1:0] arc_mem [ARC_DEPTH];
  logic [DEM_W-1:0]   dem_mem [MAX_NODES];
  logic [CNT_W-1:0]   node_cnt;
  logic [CAP_W-1:0]   capacity;

  out_word_t set_q[$];
  int        errors = 0;
  int        tx_pct;
  int        rx_pct;
  bit        hold_req;
  bit        hold_done;
  longint    cycles = 0;
  dir_row_t  dir_tab[$];

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd4000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic bit arc_hot(int a, int b, logic [VALUE_W-1:0] thr);
    if (a == b) return 1'b0;
    return arc_mem[a * MAX_NODES + b] > thr;
  endfunction

  function automatic int bfs_fill(int seed, ref logic [MAX_NODES-1:0] mask,
                                  ref int q[MAX_NODES], input int n,
                                  input logic [VALUE_W-1:0] thr);
    int hd;
    int tl;
    int cur;
    hd = 0;
    tl = 0;
    mask[seed] = 1'b1;
    q[tl++] = seed;
    while (hd < tl) begin
      cur = q[hd++];
      for (int k = 0; k < n; k++)
        if (arc_hot(cur, k, thr) && !mask[k] && tl < MAX_NODES) begin
          mask[k] = 1'b1;
          q[tl++] = k;
        end
    end
    return tl;
  endfunction

  function automatic void push_set(int node, logic kind, bit last, bit done,
                                   ref int cnt);
    out_word_t o;
    if (!done && cnt >= MAX_RESULTS - 1) return;
    o.node_id     = NODE_W'(node);
    o.set_kind    = kind;
    o.last_of_set = last;
    o.done_res    = done;
    set_q = {set_q, o};
    cnt++;
  endfunction

  function automatic void predict_find(logic [VALUE_W-1:0] thr);
    logic [MAX_NODES-1:0] reach;
    logic [MAX_NODES-1:0] proc_m;
    logic [MAX_NODES-1:0] on_route;
    int q[MAX_NODES];
    int n;
    int len;
    int cur;
    int nxt;
    int cnt;
    logic [SUM_W-1:0] sum;
    n = (node_cnt > MAX_NODES) ? MAX_NODES : int'(node_cnt);
    cnt = 0;
    reach = '0;
    void'(bfs_fill(0, reach, q, n, thr));
    proc_m = MAX_NODES'(1);
    for (int s = 1; s < n; s++) begin
      if (reach[s] || proc_m[s]) continue;
      len = bfs_fill(s, proc_m, q, n, thr);
      for (int i = 0; i < len; i++) push_set(q[i], KIND_SUBTOUR, i + 1 == len, 0, cnt);
    end
    on_route = MAX_NODES'(1);
    for (int j = 1; j < n; j++) begin
      if (!arc_hot(0, j, thr) || on_route[j]) continue;
      len = 0;
      cur = j;
      sum = '0;
      while (cur != 0 && !on_route[cur]) begin
        on_route[cur] = 1'b1;
        if (len < MAX_NODES) q[len++] = cur;
        sum = sum + SUM_W'(dem_mem[cur]);
        nxt = n;
        for (int k = 0; k < n; k++)
          if (arc_hot(cur, k, thr)) begin
            nxt = k;
            break;
          end
        if (nxt == n) break;
        cur = nxt;
      end
      if (sum > capacity && len > 0)
        for (int i = 0; i < len; i++) push_set(q[i], KIND_ROUTE, i + 1 == len, 0, cnt);
    end
    push_set(0, 1'b0, 0, 1, cnt);
  endfunction

  function automatic void apply_word(in_word_t w);
    case (op_t'(w.op))
      OP_ARC:  arc_mem[w.from_node * MAX_NODES + w.to_node] = w.arc_value;
      OP_DEM:  dem_mem[w.from_node] = w.demand;
      OP_FIND: predict_find(w.threshold);
      default: ;
    endcase
  endfunction

  // compare every accepted result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (set_q.size() == 0) begin
        $error("unexpected result word node_id=%0d", out_data.node_id);
        errors++;
      end else begin
        out_word_t e;
        e = set_q.pop_front();
        if (out_data.node_id !== e.node_id) begin
          $error("node_id expected %0d actual %0d", e.node_id, out_data.node_id);
          errors++;
        end
        if (out_data.set_kind !== e.set_kind) begin
          $error("set_kind expected %0d actual %0d", e.set_kind, out_data.set_kind);
          errors++;
        end
        if (out_data.last_of_set !== e.last_of_set) begin
          $error("last_of_set expected %0d actual %0d", e.last_of_set, out_data.last_of_set);
          errors++;
        end
        if (out_data.done_res !== e.done_res) begin
          $error("done_res expected %0d actual %0d", e.done_res, out_data.done_res);
          errors++;
        end
      end
    end
  end

  // receiver: random stall, or one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      repeat (400) @(negedge clk);
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  task automatic send_word(in_word_t w, bit typed, out_word_t ex);
    @(negedge clk);
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (typed) begin
      set_q = {set_q, ex};
    end else begin
      apply_word(w);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (set_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CAP_W-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_NODE_COUNT) node_cnt = val[CNT_W-1:0];
    else capacity = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic in_word_t mk(op_t op, int f, int t, int v, int d, int thr);
    in_word_t w;
    w.op        = op;
    w.from_node = NODE_W'(f);
    w.to_node   = NODE_W'(t);
    w.arc_value = VALUE_W'(v);
    w.demand    = DEM_W'(d);
    w.threshold = VALUE_W'(thr);
    return w;
  endfunction

  function automatic void add_cfg(logic idx, int val);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.cidx   = idx;
    r.cval   = CAP_W'(val);
    dir_tab = {dir_tab, r};
  endfunction

  function automatic void add_item(in_word_t w, bit typed, out_word_t ex);
    dir_row_t r;
    r = '{default: '0};
    r.w     = w;
    r.typed = typed;
    r.ex    = ex;
    dir_tab = {dir_tab, r};
  endfunction

  function automatic in_word_t rand_word(int n);
    in_word_t w;
    int lim;
    int p;
    lim = (n < 2) ? 2 : ((n > MAX_NODES) ? MAX_NODES : n);
    w = in_word_t'(IN_W'({$urandom, $urandom}));
    p = $urandom_range(99);
    if (p < 2) w.op = OP_NOP;
    else if (p < 12) w.op = OP_FIND;
    else if (p < 30) w.op = OP_DEM;
    else w.op = OP_ARC;
    if ($urandom_range(9) != 0) begin
      w.from_node = NODE_W'($urandom_range(lim - 1));
      w.to_node   = NODE_W'($urandom_range(lim - 1));
      // mostly sparse graphs so that components and routes form
      w.arc_value = ($urandom_range(3) == 0) ? VALUE_W'(16'h6000 + $urandom_range(16'h1fff))
                                             : VALUE_W'($urandom_range(16'h3fff));
      w.threshold = VALUE_W'($urandom_range(16'h4800, 16'h5fff));
      w.demand    = DEM_W'($urandom_range(16'h3fff));
    end
    return w;
  endfunction

  initial begin
    out_word_t none;
    out_word_t done_only;
    int ncfg [10];
    none      = '0;
    done_only = '0;
    done_only.done_res = 1'b1;
    tx_pct    = 0;
    rx_pct    = 0;
    hold_req  = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_NODE_COUNT;
    cfg_wdata = '0;
    node_cnt  = CNT_W'(32);
    capacity  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill arc and demand memories so no find reads an unwritten entry
    for (int a = 0; a < FILL_NODES; a++) begin
      send_word(mk(OP_DEM, a, 0, 0, $urandom_range(16'h0fff), 0), 0, none);
      for (int b = 0; b < FILL_NODES; b++)
        send_word(mk(OP_ARC, a, b, $urandom_range(16'h3fff), 0, 0), 0, none);
    end

    add_cfg(CFG_NODE_COUNT, 1);
    add_item(mk(OP_FIND, 0, 0, 0, 0, 0), 1, done_only);
    add_cfg(CFG_NODE_COUNT, 0);
    add_item(mk(OP_FIND, 31, 31, 16'hffff, 16'hffff, 0), 1, done_only);
    add_cfg(CFG_NODE_COUNT, FILL_NODES);
    add_cfg(CFG_CAPACITY, 0);
    add_item(mk(OP_ARC, 0, 1, 16'hffff, 0, 0), 0, none);
    add_item(mk(OP_ARC, 1, 0, 16'hffff, 0, 0), 0, none);
    add_item(mk(OP_ARC, 1, 2, 0, 0, 0), 0, none);
    add_item(mk(OP_ARC, 31, 30, 16'hffff, 0, 0), 0, none);
    add_item(mk(OP_DEM, 1, 0, 0, 16'hffff, 0), 0, none);
    add_item(mk(OP_DEM, 0, 0, 0, 0, 0), 0, none);
    add_item(mk(OP_FIND, 0, 0, 0, 0, 0), 0, none);
    add_item(mk(OP_FIND, 0, 0, 0, 0, 16'hffff), 0, none);
    add_item(mk(OP_NOP, 31, 31, 16'hffff, 16'hffff, 16'hffff), 0, none);
    add_item(mk(OP_FIND, 0, 0, 0, 0, 16'h7fff), 0, none);
    add_cfg(CFG_NODE_COUNT, 2);
    add_cfg(CFG_CAPACITY, 16'hffff);
    add_item(mk(OP_FIND, 0, 0, 0, 0, 0), 0, none);
    add_cfg(CFG_NODE_COUNT, 3);
    add_item(mk(OP_FIND, 0, 0, 0, 0, 16'hffff), 0, none);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].cidx, dir_tab[i].cval);
      else send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].ex);
    end

    ncfg = '{2, 3, 5, 8, 12, 10, 6, 12, 11, 4};
    for (int ph = 0; ph < 3; ph++) begin
      tx_pct = (ph == 0) ? 33 : ((ph == 1) ? 76 : 0);
      rx_pct = (ph == 0) ? 76 : ((ph == 1) ? 33 : 0);
      for (int seg = 0; seg < 3; seg++) begin
        write_reg(CFG_NODE_COUNT, CAP_W'(ncfg[(ph * 3 + seg + $urandom_range(1)) % 10]));
        case ($urandom_range(2))
          0: write_reg(CFG_CAPACITY, CAP_W'(0));
          1: write_reg(CFG_CAPACITY, 16'hffff);
          default: write_reg(CFG_CAPACITY, CAP_W'($urandom_range(16'h0fff, 16'h8fff)));
        endcase
        if (ph == 2 && seg == 0) begin
          @(negedge clk);
          hold_req <= 1'b1;
          repeat (6) send_word(mk(OP_FIND, 0, 0, 0, 0, $urandom_range(16'h5fff)), 0, none);
        end
        for (int k = 0; k < 26; k++) begin
          send_word(rand_word(int'(node_cnt)), 0, none);
          if (ph == 1 && seg == 1 && k == 12) wait_idle();
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (set_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
